// File: hdl/path_component_to_short_name_assert.svh
// ----------------------------------------------------------------------------
// path_component_to_short_name_assert.svh
// Assertion macros shared by the short name converter.
// ----------------------------------------------------------------------------
`ifndef PATH_COMPONENT_TO_SHORT_NAME_ASSERT_SVH
`define PATH_COMPONENT_TO_SHORT_NAME_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PC2SN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pc2sn assertion failed");

// next-cycle implication, checked out of reset
`define PC2SN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pc2sn assertion failed");

`endif

// File: hdl/pc2sn_pkg.sv
// ----------------------------------------------------------------------------
// pc2sn_pkg
// Constants and helpers for the path component to 8.3 short name converter.
// ----------------------------------------------------------------------------
package pc2sn_pkg;

	localparam int MAX_COMPONENT_LEN = 255;
	localparam int POS_W             = $clog2(MAX_COMPONENT_LEN + 1);
	localparam int LEN_W             = 8;
	localparam int NAME_SLOTS        = 11;
	localparam int SHORT_NAME_BYTES  = 12;
	localparam int EXT_BASE          = 8;
	localparam int EXT_SLOTS         = 3;
	localparam int IDX_W             = 4;
	localparam int EXT_W             = 2;
	localparam int TDATA_W           = 24;

	localparam logic [7:0] PAD_BYTE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SHORT_NAME_BYTES - 1);

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			r = c & ~CASE_BIT;
		end
		return r;
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_SLASH);
	endfunction

endpackage

// File: hdl/path_component_to_short_name.sv
// ----------------------------------------------------------------------------
// path_component_to_short_name
// Builds the space-padded 8.3 short name of each path component and sends it
// as twelve beats when the component ends on a NUL or slash byte.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   tdata[7:0] path_char
//  m_*      out  tdata[7:0] name_byte, [11:8] byte_index, [19:12] length;
//                tlast = last_byte
//
//  One path byte is taken every cycle while s_tready is high; a terminator
//  captures the name into the output register bank, which then drains one
//  beat per cycle while m_tready is high, twelve beats in all. Name bytes of
//  the next component are taken during the drain; a terminator waits only
//  until the last beat of the previous name leaves (earliest on the same
//  cycle). Arst_n clears the name buffer to spaces and empties the output.
// ----------------------------------------------------------------------------
module path_component_to_short_name
	import pc2sn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] path_char
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [7:0] name_byte, [11:8] byte_index,
	                                      // [19:12] component_length, rest 0
	output logic               m_tlast    // last_byte
);

	`include "path_component_to_short_name_assert.svh"

	logic [7:0]       name_q [NAME_SLOTS];
	logic [POS_W-1:0] pos_q;
	logic             dot_q;
	logic [EXT_W-1:0] ext_q;

	logic [7:0]       snap_q [NAME_SLOTS];
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] cnt_q;
	logic             out_valid_q;

	logic             in_beat;
	logic             out_beat;
	logic             term;
	logic             busy;
	logic [7:0]       up;
	logic [LEN_W-1:0] len_clamp;

	assign term     = is_term(s_tdata);
	assign out_beat = out_valid_q && m_tready;
	assign busy     = out_valid_q && !(m_tready && cnt_q == LAST_IDX);
	assign s_tready = !(term && busy);
	assign in_beat  = s_tvalid && s_tready;
	assign up       = to_upper(s_tdata);

	always_comb begin
		if (pos_q > POS_W'(2 ** LEN_W - 1)) begin
			len_clamp = '1;
		end else begin
			len_clamp = LEN_W'(pos_q);
		end
	end

	// component state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAME_SLOTS; i++) begin
				name_q[i] <= PAD_BYTE;
			end
			pos_q <= '0;
			dot_q <= 1'b0;
			ext_q <= '0;
		end else if (in_beat) begin
			if (term) begin
				for (int i = 0; i < NAME_SLOTS; i++) begin
					name_q[i] <= PAD_BYTE;
				end
				pos_q <= '0;
				dot_q <= 1'b0;
				ext_q <= '0;
			end else begin
				if (pos_q < POS_W'(SHORT_NAME_BYTES)) begin
					if (!dot_q) begin
						if (up == CH_DOT) begin
							dot_q <= 1'b1;
							ext_q <= '0;
						end else if (pos_q < POS_W'(NAME_SLOTS)) begin
							name_q[pos_q[IDX_W-1:0]] <= up;
						end
					end else if (ext_q < EXT_W'(EXT_SLOTS)) begin
						name_q[IDX_W'(EXT_BASE) + IDX_W'(ext_q)] <= up;
						ext_q <= ext_q + 1'b1;
					end
				end
				if (pos_q < POS_W'(MAX_COMPONENT_LEN)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (in_beat && term) begin
			out_valid_q <= 1'b1;
			cnt_q       <= '0;
		end else if (out_beat) begin
			if (cnt_q == LAST_IDX) begin
				out_valid_q <= 1'b0;
				cnt_q       <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// capture name on terminator
	always_ff @(posedge clk) begin
		if (in_beat && term) begin
			snap_q <= name_q;
			len_q  <= len_clamp;
		end
	end

	logic [7:0] out_byte;

	always_comb begin
		if (cnt_q == LAST_IDX) begin
			out_byte = CH_NUL;
		end else begin
			out_byte = snap_q[cnt_q];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_valid_q && cnt_q == LAST_IDX;
	assign m_tdata  = {(TDATA_W - LEN_W - IDX_W - 8)'(0), len_q, cnt_q, out_byte};

	`PC2SN_ASSERT_NOW(a_idle_cnt_zero, !out_valid_q, cnt_q == '0)
	`PC2SN_ASSERT_NEXT(a_term_starts_drain, in_beat && term,
		out_valid_q && cnt_q == '0 && pos_q == '0 && !dot_q)
	`PC2SN_ASSERT_NEXT(a_beat_advances, out_beat && cnt_q != LAST_IDX,
		out_valid_q && cnt_q == $past(cnt_q) + 1'b1)
	`PC2SN_ASSERT_NOW(a_ext_needs_dot, ext_q != '0, dot_q)

endmodule
